// ----- sv/psbd_pkg.sv -----
// Shared types, constants and the arctangent table of the slope-break detector.
`default_nettype none
package psbd_pkg;

  localparam int ATAN_ITERATIONS_DEF = 16;
  localparam int ATAN_TABLE_LEN      = 24;
  localparam int QUEUE_DEPTH         = 2;
  localparam logic [15:0] WIDTH_DEFAULT = 16'd256;
  localparam logic [14:0] SLOPE_MAX     = 15'd23040;

  typedef enum logic [1:0] {
    REG_MPP  = 2'd0,
    REG_TAN  = 2'd1,
    REG_DROP = 2'd2
  } reg_idx_t;

  // one candidate segment handed from front to back
  typedef struct packed {
    logic [15:0]        path;
    logic [15:0]        top_x;
    logic [15:0]        top_y;
    logic [15:0]        bot_x;
    logic [15:0]        bot_y;
    logic signed [23:0] top_h;
    logic signed [23:0] bot_h;
    logic [15:0]        adx;
    logic [15:0]        ady;
    logic [23:0]        drop;
    logic [15:0]        width;
  } job_t;

  typedef struct packed {
    logic [15:0]        fall_path;
    logic [15:0]        top_x;
    logic [15:0]        top_y;
    logic [15:0]        bottom_x;
    logic [15:0]        bottom_y;
    logic signed [23:0] top_height;
    logic signed [23:0] bottom_height;
    logic [23:0]        drop_amount;
    logic [14:0]        slope_degrees;
    logic [15:0]        fall_width;
  } res_t;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/psbd_if.sv -----
// Channel interfaces: point requests, fall records and register writes.
`default_nettype none
interface psbd_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        path_index;
  logic               first_point;
  logic               path_consistent;
  logic [15:0]        point_x;
  logic [15:0]        point_y;
  logic signed [23:0] surface_height;
  logic [15:0]        width_in;
  logic               width_present;
  modport source (output valid, path_index, first_point, path_consistent, point_x,
                  point_y, surface_height, width_in, width_present, input ready);
  modport sink (input valid, path_index, first_point, path_consistent, point_x,
                point_y, surface_height, width_in, width_present, output ready);
endinterface

interface psbd_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        fall_path;
  logic [15:0]        top_x;
  logic [15:0]        top_y;
  logic [15:0]        bottom_x;
  logic [15:0]        bottom_y;
  logic signed [23:0] top_height;
  logic signed [23:0] bottom_height;
  logic [23:0]        drop_amount;
  logic [14:0]        slope_degrees;
  logic [15:0]        fall_width;
  modport source (output valid, fall_path, top_x, top_y, bottom_x, bottom_y, top_height,
                  bottom_height, drop_amount, slope_degrees, fall_width, input ready);
  modport sink (input valid, fall_path, top_x, top_y, bottom_x, bottom_y, top_height,
                bottom_height, drop_amount, slope_degrees, fall_width, output ready);
endinterface

interface psbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/psbd_front.sv -----
// Front end: takes point requests, keeps the previous point, queues candidate segments.
`default_nettype none
module psbd_front
  import psbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  psbd_in_if.sink                 in_if,
  input  wire logic signed [23:0] min_drop,
  input  wire logic               q_full,
  output logic                    push,
  output job_t                    job
);

  logic [15:0]        prev_x_r, prev_y_r;
  logic signed [23:0] prev_h_r;
  logic               have_prev_r;
  logic               acc;
  logic signed [16:0] dx, dy;
  logic signed [24:0] drop;
  logic               keep;

  assign in_if.ready = !q_full;
  assign acc = in_if.valid && !q_full;

  always_comb begin
    dx   = $signed({1'b0, in_if.point_x}) - $signed({1'b0, prev_x_r});
    dy   = $signed({1'b0, in_if.point_y}) - $signed({1'b0, prev_y_r});
    drop = 25'(prev_h_r) - 25'(in_if.surface_height);
    // negative drops can never pass the tangent test
    keep = in_if.path_consistent && !in_if.first_point && have_prev_r &&
           (drop >= 25'(min_drop)) && !drop[24];
    job.path  = in_if.path_index;
    job.top_x = prev_x_r;
    job.top_y = prev_y_r;
    job.bot_x = in_if.point_x;
    job.bot_y = in_if.point_y;
    job.top_h = prev_h_r;
    job.bot_h = in_if.surface_height;
    job.adx   = dx[16] ? 16'(-dx) : dx[15:0];
    job.ady   = dy[16] ? 16'(-dy) : dy[15:0];
    job.drop  = drop[23:0];
    job.width = in_if.width_present ? in_if.width_in : WIDTH_DEFAULT;
  end

  assign push = acc && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_h_r    <= '0;
      have_prev_r <= 1'b0;
    end else if (acc && in_if.path_consistent) begin
      prev_x_r    <= in_if.point_x;
      prev_y_r    <= in_if.point_y;
      prev_h_r    <= in_if.surface_height;
      have_prev_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/psbd_queue.sv -----
// Short segment queue between front and back end, registered read.
`default_nettype none
module psbd_queue
  import psbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_data,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output job_t      rd_data_r
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (pop)  rd_data_r   <= mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- sv/psbd_back.sv -----
// Back end: distance, run, slope test and CORDIC angle for one segment at a time.
`default_nettype none
module psbd_back
  import psbd_pkg::*;
#(
  parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEF
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] mpp,
  input  wire logic [15:0] min_tan,
  input  wire logic        q_not_empty,
  output logic             pop,
  input  job_t             q_data,
  psbd_out_if.source       out_if
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LOAD = 10'b0000000010,
    S_SQX  = 10'b0000000100,
    S_SQY  = 10'b0000001000,
    S_ROOT = 10'b0000010000,
    S_RUN  = 10'b0000100000,
    S_PROD = 10'b0001000000,
    S_TEST = 10'b0010000000,
    S_ARC  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  job_t               job_r;
  logic [33:0]        rad_r;
  logic [19:0]        rem_r;
  logic [16:0]        root_r;
  logic [4:0]         cnt_r;
  logic [30:0]        run_r;
  logic [46:0]        prod_r;
  logic signed [35:0] x_r, y_r;
  logic signed [24:0] z_r;
  logic               out_valid_r;
  res_t               res_r;

  logic [19:0]        rem_sh, trial;
  logic [32:0]        run_full;
  logic signed [35:0] xs, ys;
  logic signed [24:0] ang, zq;
  logic [14:0]        deg;
  logic               slot_free;

  assign slot_free = !out_valid_r || out_if.ready;
  assign pop       = (state_r == S_IDLE) && q_not_empty;

  always_comb begin
    rem_sh   = {rem_r[17:0], rad_r[33:32]};
    trial    = {1'b0, root_r, 2'b01};
    run_full = root_r * mpp;
    xs       = x_r >>> cnt_r;
    ys       = y_r >>> cnt_r;
    ang      = 25'(atan_deg(cnt_r));
    zq       = (z_r + 25'sd128) >>> 8;
    if (zq[24])                          deg = '0;
    else if (zq > 25'(SLOPE_MAX))        deg = SLOPE_MAX;
    else                                 deg = zq[14:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_not_empty) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_ROOT;
      S_ROOT: if (cnt_r == '0) state_nxt = S_RUN;
      S_RUN:  state_nxt = S_PROD;
      S_PROD: state_nxt = S_TEST;
      S_TEST: state_nxt = ((run_r != '0) && ({job_r.drop, 10'b0} >= 34'(prod_r >> 0) &&
                           prod_r[46:34] == '0)) ? S_ARC : S_IDLE;
      S_ARC:  if (cnt_r == 5'(ATAN_ITERATIONS - 1)) state_nxt = S_DONE;
      S_DONE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: job_r <= q_data;
      S_SQX:  rad_r <= 34'(job_r.adx * job_r.adx);
      S_SQY: begin
        rad_r  <= rad_r + 34'(job_r.ady * job_r.ady);
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 5'd16;
      end
      S_ROOT: begin
        rad_r <= {rad_r[31:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[15:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[15:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      S_RUN:  run_r  <= run_full[32:2];
      S_PROD: prod_r <= min_tan * run_r;
      S_TEST: begin
        x_r   <= 36'(run_r);
        y_r   <= 36'({job_r.drop, 2'b00});
        z_r   <= '0;
        cnt_r <= '0;
      end
      S_ARC: begin
        if (!y_r[35]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - ang;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && slot_free) begin
      res_r.fall_path     <= job_r.path;
      res_r.top_x         <= job_r.top_x;
      res_r.top_y         <= job_r.top_y;
      res_r.bottom_x      <= job_r.bot_x;
      res_r.bottom_y      <= job_r.bot_y;
      res_r.top_height    <= job_r.top_h;
      res_r.bottom_height <= job_r.bot_h;
      res_r.drop_amount   <= job_r.drop;
      res_r.slope_degrees <= deg;
      res_r.fall_width    <= job_r.width;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.fall_path     = res_r.fall_path;
  assign out_if.top_x         = res_r.top_x;
  assign out_if.top_y         = res_r.top_y;
  assign out_if.bottom_x      = res_r.bottom_x;
  assign out_if.bottom_y      = res_r.bottom_y;
  assign out_if.top_height    = res_r.top_height;
  assign out_if.bottom_height = res_r.bottom_height;
  assign out_if.drop_amount   = res_r.drop_amount;
  assign out_if.slope_degrees = res_r.slope_degrees;
  assign out_if.fall_width    = res_r.fall_width;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE)
    else $error("queue popped outside idle");
  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == S_LOAD)
    else $error("pop not followed by load");
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done");
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.slope_degrees <= SLOPE_MAX)
    else $error("slope out of range");

endmodule
`default_nettype wire

// ----- sv/polyline_slope_break_detector.sv -----
// Top level of the polyline slope-break detector: registers, front, queue, back.
//
// Usage:
//   in_if  : one polyline point per request (valid/ready). Points of inconsistent
//            paths are dropped; a first point only primes the previous point.
//   out_if : one fall record per segment that passes the run, drop and slope tests.
//   cfg_if : register writes (index 0 metres_per_pixel, 1 min_slope_tangent,
//            2 min_drop), always ready; write only while the block is idle.
// Throughput: the front takes a point per cycle while the two-entry queue has
//   room. The back handles one segment at a time: load, squaring, the
//   bit-serial square root (17 steps), run, product, slope test, the CORDIC
//   loop (one step per cycle) and the final state. Points yielding no
//   candidate cost the back nothing.
// Reset: synchronous, active low; clears the previous point, queue and result
//   valid flag and loads the register defaults.
// Stall: a result waits in the output register; the back starts the next
//   segment meanwhile and holds in its final state until the slot frees.
`default_nettype none
module polyline_slope_break_detector
  import psbd_pkg::*;
#(
  parameter int ATAN_ITERATIONS = ATAN_ITERATIONS_DEF
)(
  input  wire logic  clk,
  input  wire logic  rst_n,
  psbd_in_if.sink    in_if,
  psbd_out_if.source out_if,
  psbd_cfg_if.sink   cfg_if
);

  logic [15:0]        mpp_r, tan_r;
  logic signed [23:0] mdrop_r;
  logic               push, q_full, q_ne, pop;
  job_t               job, q_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r   <= 16'd256;
      tan_r   <= 16'd256;
      mdrop_r <= 24'sd256;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MPP:  mpp_r   <= cfg_if.data[15:0];
        REG_TAN:  tan_r   <= cfg_if.data[15:0];
        REG_DROP: mdrop_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  psbd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .min_drop(mdrop_r),
    .q_full(q_full), .push(push), .job(job)
  );

  psbd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(job), .full(q_full),
    .not_empty(q_ne), .pop(pop), .rd_data_r(q_data)
  );

  psbd_back #(.ATAN_ITERATIONS(ATAN_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .mpp(mpp_r), .min_tan(tan_r),
    .q_not_empty(q_ne), .pop(pop), .q_data(q_data), .out_if(out_if)
  );

endmodule
`default_nettype wire
